// File: src/stpq_pkg.sv
// ----------------------------------------------------------------------------
// stpq_pkg
// Shared codes and types of the stable three-level priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package stpq_pkg;

	localparam int NUM_LEVELS        = 3;
	localparam int LVL_W             = 2;
	localparam int LEVEL_DEPTH_DEF   = 16;
	localparam int ID_BITS_DEF       = 16;

	// Input operations
	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	// Priority levels
	localparam logic [LVL_W-1:0] LVL_NONE = 2'd0;
	localparam logic [LVL_W-1:0] JUNIOR   = 2'd1;
	localparam logic [LVL_W-1:0] MID      = 2'd2;
	localparam logic [LVL_W-1:0] SENIOR   = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic enq;  // enqueue transfer this cycle
		logic deq;  // dequeue transfer this cycle
		logic fin;  // dequeue read data ready, load result
	} stpq_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic any_held;  // at least one level holds an entry
	} stpq_stat_t;

endpackage

`default_nettype wire

// File: src/stable_three_level_priority_queue_core.sv
// ----------------------------------------------------------------------------
// stable_three_level_priority_queue_core
// Three-level priority queue of item ids, FIFO order within a level.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries op, item_id, item_level.
//   op = enqueue stores item_id at item_level (level 0 counts as level 1);
//   op = dequeue pops the oldest entry of the highest non-empty level.
//   Every input transfer produces exactly one result on the output channel
//   (out_valid/out_ready): status, out_id, out_level, queue_empty.
// Result path:
//   Enqueue and empty dequeue: result valid in the cycle after the transfer.
//   Dequeue of a held entry: the id passes the registered read port of the
//   entry memory, then the result register. No input is taken during the read.
// Stall:
//   The result register holds until taken; a new input transfer is taken in
//   the same cycle the previous result leaves. While a result waits and
//   out_ready is low, in_ready stays low.
// Reset:
//   arst_n clears all pointers, counts and handshake state: all levels empty.
//   Entry memory is not cleared; only written slots are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_three_level_priority_queue_core #(
	parameter int LEVEL_DEPTH = stpq_pkg::LEVEL_DEPTH_DEF,
	parameter int ID_BITS     = stpq_pkg::ID_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        op,
	input  wire logic [ID_BITS-1:0]          item_id,
	input  wire logic [stpq_pkg::LVL_W-1:0]  item_level,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [1:0]                       status,
	output logic [ID_BITS-1:0]               out_id,
	output logic [stpq_pkg::LVL_W-1:0]       out_level,
	output logic                             queue_empty
);

	stpq_pkg::stpq_cmd_t  cmd;
	stpq_pkg::stpq_stat_t stat;

	// sequencing of transfers and the dequeue read
	stpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// FIFO state, entry memory and result register
	stpq_dp #(
		.LEVEL_DEPTH (LEVEL_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.item_id     (item_id),
		.item_level  (item_level),
		.status      (status),
		.out_id      (out_id),
		.out_level   (out_level),
		.queue_empty (queue_empty)
	);

endmodule

`default_nettype wire

// File: src/stpq_ctrl.sv
// ----------------------------------------------------------------------------
// stpq_ctrl
// Handshake controller: input/output valid-ready and dequeue read sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module stpq_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  op,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	input  wire stpq_pkg::stpq_stat_t  stat,
	output stpq_pkg::stpq_cmd_t        cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic in_xfer;
	logic deq_wait;
	logic load;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign in_xfer  = in_valid && in_ready;
	assign deq_wait = in_xfer && (op == stpq_pkg::OP_DEQ) && stat.any_held;

	assign cmd.enq = in_xfer && (op == stpq_pkg::OP_ENQ);
	assign cmd.deq = in_xfer && (op == stpq_pkg::OP_DEQ);
	assign cmd.fin = (state_q == S_READ);

	// result ready now: enqueue, empty dequeue, or finished read
	assign load = (in_xfer && !deq_wait) || (state_q == S_READ);

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (deq_wait) state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// output register is free while a read is pending
	a_read_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> !out_valid_q)
		else $error("result pending while read in flight");

	// a held dequeue always goes through the read state
	a_deq_read: assert property (@(posedge clk) disable iff (!arst_n)
		deq_wait |=> (state_q == S_READ))
		else $error("dequeue skipped read state");

	// results appear only from a transfer or a finished read
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(in_xfer) || $past(state_q == S_READ)))
		else $error("result without a cause");

endmodule

`default_nettype wire

// File: src/stpq_dp.sv
// ----------------------------------------------------------------------------
// stpq_dp
// Datapath: per-level FIFO pointers and counts, entry memory, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stpq_dp #(
	parameter int LEVEL_DEPTH = stpq_pkg::LEVEL_DEPTH_DEF,
	parameter int ID_BITS     = stpq_pkg::ID_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire stpq_pkg::stpq_cmd_t          cmd,
	output stpq_pkg::stpq_stat_t              stat,
	input  wire logic [ID_BITS-1:0]           item_id,
	input  wire logic [stpq_pkg::LVL_W-1:0]   item_level,
	output logic [1:0]                        status,
	output logic [ID_BITS-1:0]                out_id,
	output logic [stpq_pkg::LVL_W-1:0]        out_level,
	output logic                              queue_empty
);

	localparam int NL     = stpq_pkg::NUM_LEVELS;
	localparam int LW     = stpq_pkg::LVL_W;
	localparam int PTR_W  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
	localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
	localparam int ENTRIES = NL * LEVEL_DEPTH;
	localparam int ADDR_W = $clog2(ENTRIES);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(LEVEL_DEPTH - 1);

	logic [PTR_W-1:0] rd_ptr_q [NL];
	logic [PTR_W-1:0] wr_ptr_q [NL];
	logic [CNT_W-1:0] count_q  [NL];
	logic [ID_BITS-1:0] mem [ENTRIES];
	logic [ID_BITS-1:0] rd_data_q;
	logic [LW-1:0]      deq_lvl_q;

	logic [LW-1:0]     enq_q;     // level index 0..2
	logic [LW-1:0]     pick;      // highest non-empty level index
	logic              enq_full;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic              all_zero;

	always_comb begin
		if (item_level == stpq_pkg::LVL_NONE) enq_q = stpq_pkg::JUNIOR - 2'd1;
		else enq_q = item_level - 2'd1;
	end

	always_comb begin
		priority if (count_q[2] != '0) pick = 2'd2;
		else if (count_q[1] != '0)     pick = 2'd1;
		else                           pick = 2'd0;
	end

	assign stat.any_held = (count_q[0] != '0) || (count_q[1] != '0) || (count_q[2] != '0);
	assign all_zero      = !stat.any_held;
	assign enq_full      = (count_q[enq_q] == CNT_W'(LEVEL_DEPTH));

	assign wr_addr = ADDR_W'(enq_q) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(wr_ptr_q[enq_q]);
	assign rd_addr = ADDR_W'(pick) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(rd_ptr_q[pick]);

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		next_slot = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	// pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NL; i++) begin
				rd_ptr_q[i] <= '0;
				wr_ptr_q[i] <= '0;
				count_q[i]  <= '0;
			end
		end else begin
			if (cmd.enq && !enq_full) begin
				wr_ptr_q[enq_q] <= next_slot(wr_ptr_q[enq_q]);
				count_q[enq_q]  <= count_q[enq_q] + CNT_W'(1);
			end
			if (cmd.deq && stat.any_held) begin
				rd_ptr_q[pick] <= next_slot(rd_ptr_q[pick]);
				count_q[pick]  <= count_q[pick] - CNT_W'(1);
			end
		end
	end

	// entry memory, registered read; only held slots are read
	always_ff @(posedge clk) begin
		if (cmd.enq && !enq_full) mem[wr_addr] <= item_id;
		if (cmd.deq && stat.any_held) begin
			rd_data_q <= mem[rd_addr];
			deq_lvl_q <= pick;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			status      <= stpq_pkg::ST_OK;
			out_id      <= rd_data_q;
			out_level   <= deq_lvl_q + 2'd1;
			queue_empty <= all_zero;
		end else if (cmd.enq) begin
			status      <= enq_full ? stpq_pkg::ST_FULL : stpq_pkg::ST_OK;
			out_id      <= '0;
			out_level   <= stpq_pkg::LVL_NONE;
			queue_empty <= 1'b0;
		end else if (cmd.deq && !stat.any_held) begin
			status      <= stpq_pkg::ST_EMPTY;
			out_id      <= '0;
			out_level   <= stpq_pkg::LVL_NONE;
			queue_empty <= 1'b1;
		end
	end

endmodule

`default_nettype wire
